/* hdl/mvcs_pkg.sv */
// ----------------------------------------------------------------------------
// mvcs_pkg
// Shared types and constants for the maximal visibility code set block.
// ----------------------------------------------------------------------------
package mvcs_pkg;

  localparam int CODE_W  = 16;
  localparam int FRAME_W = 16;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [FRAME_W-1:0] frame;
    logic               last;
  } mvcs_item_t;

endpackage

/* hdl/mvcs_front.sv */
// ----------------------------------------------------------------------------
// mvcs_front
// Accepts frames, masks the code to the marker count and numbers each frame
// with a saturating counter that restarts after the last frame.
// ----------------------------------------------------------------------------
module mvcs_front #(
  parameter int MARKERS    = 16,
  parameter int FRAME_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mvcs_pkg::CODE_W-1:0]      visible_mask,
  input  logic                             last_frame,
  output logic                             push_valid,
  input  logic                             push_ready,
  output mvcs_pkg::mvcs_item_t             push_item
);
  import mvcs_pkg::*;

  localparam logic [CODE_W-1:0] MARKER_MASK =
    (MARKERS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((64'd1 << MARKERS) - 64'd1);
  localparam int FRAME_OUT_W = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

  logic [FRAME_BITS-1:0] frame_cnt;
  logic                  accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  assign push_item.code  = visible_mask & MARKER_MASK;
  assign push_item.frame = FRAME_W'(frame_cnt[FRAME_OUT_W-1:0]);
  assign push_item.last  = last_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt <= '0;
    end else if (accept) begin
      if (last_frame) begin
        frame_cnt <= '0;
      end else if (frame_cnt != FRAME_MAX) begin
        frame_cnt <= frame_cnt + 1'b1;
      end
    end
  end

endmodule

/* hdl/mvcs_queue.sv */
// ----------------------------------------------------------------------------
// mvcs_queue
// Two-entry item queue between the front and back parts.
// ----------------------------------------------------------------------------
module mvcs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  mvcs_pkg::mvcs_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output mvcs_pkg::mvcs_item_t pop_item
);
  import mvcs_pkg::*;

  mvcs_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop_ready) |=> (count == 2'd2))
    else $error("full queue lost an item");

endmodule

/* hdl/mvcs_back.sv */
// ----------------------------------------------------------------------------
// mvcs_back
// Walks the code table for each item, drops covered codes, invalidates
// covered entries, appends new codes and emits the set on the last frame.
// ----------------------------------------------------------------------------
module mvcs_back #(
  parameter int ENTRIES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  mvcs_pkg::mvcs_item_t         pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mvcs_pkg::FRAME_W-1:0] frame_number,
  output logic [mvcs_pkg::CODE_W-1:0]  code_mask,
  output logic                         last_entry,
  output logic                         overflow
);
  import mvcs_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SCAN      = 6'b000010,
    ST_COMMIT    = 6'b000100,
    ST_EMIT_RD   = 6'b001000,
    ST_EMIT_WAIT = 6'b010000,
    ST_EMIT_OUT  = 6'b100000
  } state_t;

  state_t state;

  logic [CODE_W-1:0]  code_mem  [ENTRIES];
  logic [FRAME_W-1:0] frame_mem [ENTRIES];
  logic [CODE_W-1:0]  rd_code;
  logic [FRAME_W-1:0] rd_frame;

  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] kill;
  logic [ENTRIES-1:0] new_bit;
  logic [ENTRIES-1:0] above;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   data_idx;
  logic               data_vld;
  logic               covered;
  logic               overflow_seen;

  logic [CODE_W-1:0]  cur_code;
  logic [FRAME_W-1:0] cur_frame;
  logic               cur_last;

  logic               issue;
  logic               wr_en;
  logic               more;

  assign pop_ready = (state == ST_IDLE);
  assign issue     = (state == ST_SCAN) && (scan_idx < used);
  assign wr_en     = (state == ST_COMMIT) && !covered && (used < FULL);

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      new_bit[j] = (CNT_W'(j) == used);
      above[j]   = (CNT_W'(j) > scan_idx);
    end
    more = |(valid & above);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[used[IDX_W-1:0]]  <= cur_code;
      frame_mem[used[IDX_W-1:0]] <= cur_frame;
    end
    rd_code  <= code_mem[scan_idx[IDX_W-1:0]];
    rd_frame <= frame_mem[scan_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (data_vld) begin
      kill[data_idx] <= valid[data_idx] && ((rd_code & ~cur_code) == '0);
    end
    data_idx <= scan_idx[IDX_W-1:0];
    if (state == ST_IDLE && pop_valid) begin
      cur_code  <= pop_item.code;
      cur_frame <= pop_item.frame;
      cur_last  <= pop_item.last;
    end
    if (state == ST_EMIT_WAIT) begin
      frame_number <= rd_frame;
      code_mask    <= rd_code;
      last_entry   <= !more;
      overflow     <= overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      used          <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      data_vld      <= 1'b0;
      scan_idx      <= '0;
      covered       <= 1'b0;
    end else begin
      data_vld <= issue;
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            scan_idx <= '0;
            covered  <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) scan_idx <= scan_idx + 1'b1;
          if (data_vld && valid[data_idx] && ((cur_code & ~rd_code) == '0)) begin
            covered <= 1'b1;
          end
          if (!issue && !data_vld) state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (!covered) begin
            if (used < FULL) begin
              valid <= (valid & ~kill) | new_bit;
              used  <= used + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          scan_idx <= '0;
          state    <= cur_last ? ST_EMIT_RD : ST_IDLE;
        end
        ST_EMIT_RD: begin
          if (scan_idx == used) begin
            valid         <= '0;
            used          <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_IDLE;
          end else if (valid[scan_idx[IDX_W-1:0]]) begin
            state <= ST_EMIT_WAIT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_EMIT_WAIT: begin
          out_valid <= 1'b1;
          state     <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            scan_idx  <= scan_idx + 1'b1;
            state     <= ST_EMIT_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= FULL) else $error("table fill beyond depth");
  a_valid_below_used: assert property (@(posedge clk) disable iff (rst)
    (valid & ~((ENTRIES)'({ENTRIES{1'b1}}) >> (CNT_W'(ENTRIES) - used))) == '0
    || used == '0 && valid == '0)
    else $error("valid entry above fill count");
  a_last_ends_set: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_entry) |=> !out_valid)
    else $error("item emitted after final entry");
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_seen) |-> (used == FULL))
    else $error("overflow flagged with free entries");

endmodule

/* hdl/maximal_visibility_code_set_top.sv */
// ----------------------------------------------------------------------------
// maximal_visibility_code_set_top
// Keeps the set of maximal marker-visibility codes over a frame sequence.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one item per frame, visible_mask and
// last_frame. A two-item queue sits behind the input, so the sender can run
// ahead of the table walk by two items.
// Output channel (out_valid/out_ready): on an item with last_frame set, one
// item per kept code in insertion order, the final one with last_entry set;
// overflow reports a code dropped on a full table. The set then clears.
// Table walk: each item reads the code memory one entry per cycle over the
// used entries, where used is the number of appended entries, at most
// ENTRIES. On the last frame the emit pass visits every appended entry,
// kept or invalidated.
// A stalled receiver holds the output register and the walk waits; input
// items still fill the queue. Reset empties the set and the queue and
// restarts frame numbering at 0. The code memory needs no clearing.
// ----------------------------------------------------------------------------
module maximal_visibility_code_set_top #(
  parameter int MARKERS    = 16,
  parameter int ENTRIES    = 32,
  parameter int FRAME_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mvcs_pkg::CODE_W-1:0]  visible_mask,
  input  logic                         last_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mvcs_pkg::FRAME_W-1:0] frame_number,
  output logic [mvcs_pkg::CODE_W-1:0]  code_mask,
  output logic                         last_entry,
  output logic                         overflow
);
  import mvcs_pkg::*;

  mvcs_item_t push_item;
  mvcs_item_t pop_item;
  logic       push_valid;
  logic       push_ready;
  logic       pop_valid;
  logic       pop_ready;

  mvcs_front #(
    .MARKERS    (MARKERS),
    .FRAME_BITS (FRAME_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .visible_mask (visible_mask),
    .last_frame   (last_frame),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  mvcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  mvcs_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_number (frame_number),
    .code_mask    (code_mask),
    .last_entry   (last_entry),
    .overflow     (overflow)
  );

endmodule

/* bench/code_set_checker.sv */
// ----------------------------------------------------------------------------
// code_set_checker
// Watches both channels of the maximal visibility code set block, keeps its
// own copy of the code table, and compares every emitted entry with the
// oldest one it predicted. Failures are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module code_set_checker #(
  parameter int MARKERS    = 16,
  parameter int ENTRIES    = 32,
  parameter int FRAME_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [mvcs_pkg::CODE_W-1:0]  visible_mask,
  input  logic                         last_frame,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [mvcs_pkg::FRAME_W-1:0] frame_number,
  input  logic [mvcs_pkg::CODE_W-1:0]  code_mask,
  input  logic                         last_entry,
  input  logic                         overflow,
  output int                           errors,
  output int                           entries_pending
);
  import mvcs_pkg::*;

  localparam logic [CODE_W-1:0] MARKER_MASK =
    MARKERS >= CODE_W ? {CODE_W{1'b1}} : CODE_W'((1 << MARKERS) - 1);
  localparam logic [31:0] FRAME_MAX =
    FRAME_BITS >= 32 ? 32'hFFFF_FFFF : 32'((64'd1 << FRAME_BITS) - 1);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [CODE_W-1:0]  code;
    logic               last;
    logic               ovf;
  } kept_entry_t;

  kept_entry_t       entries_due[$];
  logic [CODE_W-1:0] code_tab [ENTRIES];
  logic [31:0]       frame_tab [ENTRIES];
  logic              live [ENTRIES];
  int                used;
  logic [31:0]       frame_cnt;
  logic              ovf_seen;

  initial begin
    errors = 0;
    entries_pending = 0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic clear_set();
    for (int i = 0; i < ENTRIES; i++) live[i] = 1'b0;
    used = 0;
    frame_cnt = '0;
    ovf_seen = 1'b0;
  endtask

  // one frame through the code table; on the last frame the live entries
  // are queued in insertion order and the set clears
  task automatic absorb_frame(input logic [CODE_W-1:0] mask, input logic is_last);
    logic [CODE_W-1:0] code;
    logic              covered;
    kept_entry_t       e;
    int                last_idx;
    code = mask & MARKER_MASK;
    covered = 1'b0;
    for (int i = 0; i < used; i++)
      if (live[i] && (code & ~code_tab[i]) == '0) covered = 1'b1;
    if (!covered) begin
      if (used >= ENTRIES) begin
        ovf_seen = 1'b1;
      end else begin
        for (int i = 0; i < used; i++)
          if (live[i] && (code_tab[i] & ~code) == '0) live[i] = 1'b0;
        code_tab[used] = code;
        frame_tab[used] = frame_cnt;
        live[used] = 1'b1;
        used++;
      end
    end
    if (frame_cnt < FRAME_MAX) frame_cnt++;
    if (is_last) begin
      last_idx = -1;
      for (int i = 0; i < used; i++) begin
        if (live[i]) begin
          e.frame = frame_tab[i][FRAME_W-1:0];
          e.code  = code_tab[i];
          e.last  = 1'b0;
          e.ovf   = ovf_seen;
          entries_due.insert(entries_due.size(), e);
          last_idx = entries_due.size() - 1;
        end
      end
      if (last_idx >= 0) entries_due[last_idx].last = 1'b1;
      clear_set();
    end
  endtask

  always @(posedge clk) begin : watch
    kept_entry_t want;
    if (rst) begin
      clear_set();
      entries_due.delete();
    end else begin
      if (in_valid && in_ready) absorb_frame(visible_mask, last_frame);
      if (out_valid && out_ready) begin
        if (entries_due.size() == 0) begin
          report_mismatch($sformatf("unexpected entry frame %0d code %h",
                                    frame_number, code_mask));
        end else begin
          want = entries_due.pop_front();
          if (frame_number !== want.frame)
            report_mismatch($sformatf("frame_number got %0d want %0d",
                                      frame_number, want.frame));
          if (code_mask !== want.code)
            report_mismatch($sformatf("code_mask got %h want %h",
                                      code_mask, want.code));
          if (last_entry !== want.last)
            report_mismatch($sformatf("last_entry got %b want %b (code %h)",
                                      last_entry, want.last, want.code));
          if (overflow !== want.ovf)
            report_mismatch($sformatf("overflow got %b want %b (code %h)",
                                      overflow, want.ovf, want.code));
        end
      end
    end
    entries_pending = entries_due.size();
  end

endmodule

/* bench/tb_maximal_visibility_code_set_top.sv */
// ----------------------------------------------------------------------------
// tb_maximal_visibility_code_set_top
// Drives frame sequences into the code set block: directed cases for covered,
// superseding and equal codes, then random sequences (noise, related codes,
// and wide antichains that overflow the table) under several sender and
// receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_maximal_visibility_code_set_top;
  import mvcs_pkg::*;

  localparam int RUN_LIMIT = 8_000_000;

  typedef enum int {SEQ_NOISE, SEQ_MIXED, SEQ_WIDE} frame_run_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CODE_W-1:0]  visible_mask = '0;
  logic               last_frame = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FRAME_W-1:0] frame_number;
  logic [CODE_W-1:0]  code_mask;
  logic               last_entry;
  logic               overflow;

  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 cycles = 0;
  int                 frames_sent = 0;
  int                 fails;
  int                 pending;
  logic [CODE_W-1:0]  recent_codes[$];

  maximal_visibility_code_set_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .visible_mask(visible_mask), .last_frame(last_frame),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_number(frame_number), .code_mask(code_mask),
    .last_entry(last_entry), .overflow(overflow)
  );

  code_set_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .visible_mask(visible_mask), .last_frame(last_frame),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_number(frame_number), .code_mask(code_mask),
    .last_entry(last_entry), .overflow(overflow),
    .errors(fails), .entries_pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_frame(input logic [CODE_W-1:0] m, input logic l);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    visible_mask <= m;
    last_frame   <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
    recent_codes.insert(recent_codes.size(), m);
    if (recent_codes.size() > 8) void'(recent_codes.pop_front());
  endtask

  // eight markers visible: two such codes are never strict subsets
  function automatic logic [CODE_W-1:0] wide_code();
    logic [CODE_W-1:0] c;
    c = '0;
    while ($countones(c) < 8) c[$urandom_range(0, CODE_W-1)] = 1'b1;
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] related_code();
    logic [CODE_W-1:0] prev;
    int                pick;
    pick = $urandom_range(0, 9);
    prev = recent_codes.size() != 0 ?
           recent_codes[$urandom_range(0, recent_codes.size() - 1)] : '0;
    case (pick)
      0: return '0;
      1: return '1;
      2, 3: return prev & CODE_W'($urandom);
      4, 5: return prev | (CODE_W'(1) << $urandom_range(0, CODE_W-1));
      6: return prev;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  task automatic run_sequence(input frame_run_t kind);
    int                len;
    logic [CODE_W-1:0] c;
    recent_codes.delete();
    case (kind)
      SEQ_NOISE: len = $urandom_range(1, 5);
      SEQ_MIXED: len = $urandom_range(1, 20);
      default:   len = $urandom_range(30, 40);
    endcase
    for (int k = 0; k < len; k++) begin
      case (kind)
        SEQ_NOISE: c = CODE_W'($urandom);
        SEQ_MIXED: c = related_code();
        default:   c = ($urandom_range(0, 7) == 0) ? related_code() : wide_code();
      endcase
      send_frame(c, k == len - 1);
    end
  endtask

  task automatic random_phase(input int idle, input int stall, input int quota);
    int          start;
    int          r;
    frame_run_t  kind;
    idle_pct  = idle;
    stall_pct = stall;
    start = frames_sent;
    while (frames_sent - start < quota) begin
      r = $urandom_range(0, 9);
      kind = r < 2 ? SEQ_NOISE : (r < 8 ? SEQ_MIXED : SEQ_WIDE);
      run_sequence(kind);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single-frame sequences at the mask extremes
    send_frame(16'h0000, 1'b1);
    send_frame(16'hFFFF, 1'b1);
    // equal, superseding, covered and incomparable codes
    send_frame(16'h0001, 1'b0);
    send_frame(16'h0001, 1'b0);
    send_frame(16'h0003, 1'b0);
    send_frame(16'h0002, 1'b0);
    send_frame(16'h00F0, 1'b0);
    send_frame(16'hFF00, 1'b0);
    send_frame(16'h0000, 1'b0);
    send_frame(16'h8000, 1'b1);
    // last frame covered by an earlier entry
    send_frame(16'hFFFF, 1'b0);
    send_frame(16'h1234, 1'b1);
    // last frame supersedes everything
    send_frame(16'hAAAA, 1'b0);
    send_frame(16'h5555, 1'b0);
    send_frame(16'hFFFF, 1'b1);
    // short sequence ending in a superset
    send_frame(16'h0001, 1'b0);
    send_frame(16'h0004, 1'b0);
    send_frame(16'h0003, 1'b1);

    random_phase(0, 0, 40);
    random_phase(53, 0, 40);
    random_phase(0, 53, 40);
    random_phase(7, 7, 40);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fails == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
